// ----- sv/lscc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_pkg: shared types and constants for the cycle capture unit
// Sizes of the capture store, command codes, phases and the queue entry
// passed from the front end to the store back end.
// ----------------------------------------------------------------------------
package lscc_pkg;

  // Capture geometry
  localparam int NUM_ROWS    = 8;
  localparam int ROW_DEPTH   = 128;
  localparam int SAMPLE_BITS = 12;

  // Interface field widths
  localparam int PERIOD_W = 16;
  localparam int RROW_W   = 3;
  localparam int RPOS_W   = 7;
  localparam int RLEN_W   = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(200);

  // Derived widths
  localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int ROW_IDX_W = $clog2(NUM_ROWS + 1);
  localparam int POS_W     = $clog2(ROW_DEPTH);
  localparam int LEN_W     = $clog2(ROW_DEPTH + 1);
  localparam int ADDR_W    = ROW_W + POS_W;
  localparam int MEM_DEPTH = NUM_ROWS * ROW_DEPTH;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_START    = 2'd0,
    PH_SAMPLING = 2'd1,
    PH_WAITING  = 2'd2,
    PH_EOC      = 2'd3
  } phase_t;

  // One store operation plus the result fields already known by the front
  typedef struct packed {
    logic                   wr;
    logic                   rd_hit;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] data;
    logic                   status;
    logic                   stored;
    logic                   overflow;
    logic [RLEN_W-1:0]      rlen;
  } op_t;

endpackage

// ----- sv/lscc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_front: command decode and capture control
// Takes one item per cycle while the queue has room, runs the capture phases,
// row lengths and sample countdown, and hands a store operation to the queue.
// ----------------------------------------------------------------------------
module lscc_front
  import lscc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [PERIOD_W-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic                   new_cycle,
  input  logic [RROW_W-1:0]      read_row,
  input  logic [RPOS_W-1:0]      read_position,
  input  logic                   q_full,
  output logic                   q_push,
  output op_t                    q_data
);

  phase_t               phase, phase_next;
  logic                 edge_pending, edge_pending_next;
  logic [ROW_IDX_W-1:0] row_index, row_index_next;
  logic [PERIOD_W-1:0]  countdown, countdown_next;
  logic                 status_flag, status_flag_next;
  logic [LEN_W-1:0]     cur_len, cur_len_next;
  logic [PERIOD_W-1:0]  sample_period;
  logic [LEN_W-1:0]     row_lengths [NUM_ROWS];
  logic                 lens_clear;
  logic                 len_we;
  logic [LEN_W-1:0]     rd_len;

  // No item is taken while reset is held
  assign in_ready = !q_full && !rst;
  assign q_push   = in_valid && in_ready;

  // Period register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      sample_period <= cfg_data;
    end
  end

  // Row length looked up for a read
  always_comb begin
    if (int'(read_row) < NUM_ROWS) begin
      rd_len = row_lengths[read_row[ROW_W-1:0]];
    end else begin
      rd_len = '0;
    end
  end

  // Next state and store operation
  always_comb begin
    logic                 ep;
    logic                 act;
    logic [ROW_IDX_W-1:0] row_sel;
    logic [LEN_W-1:0]     len_cur;
    logic [PERIOD_W-1:0]  cd_dec;

    ep                = edge_pending | new_cycle;
    act               = 1'b0;
    row_sel           = row_index;
    len_cur           = cur_len;
    cd_dec            = (countdown != '0) ? countdown - 1'b1 : '0;
    phase_next        = phase;
    edge_pending_next = edge_pending;
    row_index_next    = row_index;
    countdown_next    = countdown;
    status_flag_next  = status_flag;
    cur_len_next      = cur_len;
    lens_clear        = 1'b0;
    len_we            = 1'b0;
    q_data            = '0;

    unique case (command)
      CMD_TICK: begin
        unique case (phase)
          PH_START: begin
            if (ep) begin
              ep               = 1'b0;
              phase_next       = PH_SAMPLING;
              status_flag_next = 1'b0;
            end
          end
          PH_SAMPLING: act = 1'b1;
          PH_WAITING: begin
            countdown_next = cd_dec;
            if (cd_dec == '0 || ep) begin
              act = 1'b1;
            end
          end
          default: ;
        endcase

        // Sampling action: reload, take a pending edge, then end the capture, append or drop
        if (act) begin
          countdown_next = (sample_period == '0) ? PERIOD_W'(1) : sample_period;
          phase_next     = PH_WAITING;
          if (ep) begin
            ep      = 1'b0;
            row_sel = row_index + 1'b1;
            len_cur = '0;
          end
          row_index_next = row_sel;
          cur_len_next   = len_cur;
          if (row_sel >= ROW_IDX_W'(NUM_ROWS)) begin
            phase_next       = PH_EOC;
            status_flag_next = 1'b1;
          end else if (len_cur >= LEN_W'(ROW_DEPTH)) begin
            q_data.overflow = 1'b1;
          end else begin
            q_data.wr     = 1'b1;
            q_data.addr   = {row_sel[ROW_W-1:0], len_cur[POS_W-1:0]};
            q_data.data   = adc_sample;
            q_data.stored = 1'b1;
            cur_len_next  = len_cur + 1'b1;
            len_we        = 1'b1;
          end
        end
        edge_pending_next = ep;
      end
      CMD_CLEAR: begin
        phase_next        = PH_START;
        edge_pending_next = 1'b0;
        row_index_next    = '0;
        countdown_next    = '0;
        status_flag_next  = 1'b1;
        cur_len_next      = '0;
        lens_clear        = 1'b1;
      end
      CMD_READ: begin
        q_data.rlen   = RLEN_W'(rd_len);
        q_data.rd_hit = (LEN_W'(read_position) < rd_len);
        q_data.addr   = {read_row[ROW_W-1:0], read_position[POS_W-1:0]};
      end
      default: ;
    endcase

    q_data.status = status_flag_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      edge_pending <= 1'b0;
      row_index    <= '0;
      countdown    <= '0;
      status_flag  <= 1'b1;
      cur_len      <= '0;
    end else if (q_push) begin
      phase        <= phase_next;
      edge_pending <= edge_pending_next;
      row_index    <= row_index_next;
      countdown    <= countdown_next;
      status_flag  <= status_flag_next;
      cur_len      <= cur_len_next;
    end
  end

  // Row lengths: cleared together, one row bumped per stored sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ROWS; i++) row_lengths[i] <= '0;
    end else if (q_push) begin
      if (lens_clear) begin
        for (int i = 0; i < NUM_ROWS; i++) row_lengths[i] <= '0;
      end else if (len_we) begin
        row_lengths[q_data.addr[ADDR_W-1 -: ROW_W]] <= cur_len_next;
      end
    end
  end

  // A finished capture always reports completed
  a_eoc_status: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EOC |-> status_flag)
    else $error("capture ended without completed status");

  // Capture in progress only while sampling or waiting
  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    !status_flag |-> (phase == PH_SAMPLING || phase == PH_WAITING))
    else $error("status busy outside sampling phases");

  // Before the first edge nothing has advanced
  a_start_row: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> (row_index == '0 && cur_len == '0))
    else $error("row state not clear in start phase");

  // A tick either stores or drops, never both
  a_store_xor_drop: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !(q_data.stored && q_data.overflow))
    else $error("sample both stored and dropped");

endmodule

// ----- sv/lscc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_queue: short operation queue
// Register-based FIFO that lets the front end and the store back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module lscc_queue
  import lscc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  pop_data
);

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ----- sv/lscc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscc_back: sample store and result register
// Executes queued writes and reads on the sample memory and holds one
// result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lscc_back
  import lscc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  op_t                    q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   capture_status,
  output logic                   stored,
  output logic                   overflow,
  output logic [SAMPLE_BITS-1:0] read_sample,
  output logic [RLEN_W-1:0]      read_length
);

  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_hit;

  assign q_pop       = q_valid && (!out_valid || out_ready);
  assign read_sample = rd_hit ? rd_data : '0;

  // Sample memory: one write or one registered read per operation
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.wr) begin
        mem[q_data.addr] <= q_data.data;
      end else if (q_data.rd_hit) begin
        rd_data <= mem[q_data.addr];
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      capture_status <= q_data.status;
      stored         <= q_data.stored;
      overflow       <= q_data.overflow;
      rd_hit         <= q_data.rd_hit;
      read_length    <= q_data.rlen;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- sv/line_synced_cycle_capture_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_synced_cycle_capture_unit: mains-synchronous ADC capture
// Stores ADC samples in rows, one row per mains cycle, and reads them back.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready): one item per command. Tick items carry
//   adc_sample and new_cycle; clear empties all rows and re-arms capture;
//   read returns one stored sample and the length of its row.
//   out channel (out_valid/out_ready): exactly one result item per input
//   item, in order.
//   cfg channel (cfg_valid/cfg_ready): writes sample_period; ready whenever
//   reset is released. Write it only while no items are in flight.
// Timing:
//   An accepted item enters the queue; its result is then held in the
//   result register. One item per cycle is sustained while out_ready is high;
//   the control update happens in the front end in the accept cycle, the store
//   access in the back end from the queue, one memory write or read per cycle.
// Stalls:
//   While out_ready is low, up to four items collect in the queue behind the
//   result register; in_ready then drops until the receiver takes a result.
// Reset:
//   rst clears the queue and the result, sets sample_period to 200, empties
//   all rows and waits for the first cycle edge. Stored samples are not
//   cleared; positions beyond a row's length always read as zero.
// ----------------------------------------------------------------------------
module line_synced_cycle_capture_unit
  import lscc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [PERIOD_W-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic                   new_cycle,
  input  logic [RROW_W-1:0]      read_row,
  input  logic [RPOS_W-1:0]      read_position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   capture_status,
  output logic                   stored,
  output logic                   overflow,
  output logic [SAMPLE_BITS-1:0] read_sample,
  output logic [RLEN_W-1:0]      read_length
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  op_t  push_op;
  op_t  pop_op;

  assign cfg_ready = !rst;

  // Front end: decode and capture control
  lscc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .adc_sample    (adc_sample),
    .new_cycle     (new_cycle),
    .read_row      (read_row),
    .read_position (read_position),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_op)
  );

  // Operation queue
  lscc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_op)
  );

  // Back end: sample store and result
  lscc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (pop_op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .capture_status (capture_status),
    .stored         (stored),
    .overflow       (overflow),
    .read_sample    (read_sample),
    .read_length    (read_length)
  );

endmodule

// ----- tb/tb_line_synced_cycle_capture_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_synced_cycle_capture_unit: self-checking bench for the capture unit
// A queue-fed driver sends tick, clear and read items with random gaps. A
// clocked monitor checks every result against an in-bench model of the
// capture state and row store. sample_period is rewritten between phases
// while the unit is idle. Random captures run whole sequences of mains cycles
// with noise mixed in.
// ----------------------------------------------------------------------------
module tb_line_synced_cycle_capture_unit;
  import lscc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 1000;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]             command;
    logic [SAMPLE_BITS-1:0] adc;
    logic                   new_cycle;
    logic [RROW_W-1:0]      row;
    logic [RPOS_W-1:0]      pos;
  } capture_item_t;

  typedef struct packed {
    logic                   status;
    logic                   stored;
    logic                   overflow;
    logic [SAMPLE_BITS-1:0] sample;
    logic [RLEN_W-1:0]      length;
  } capture_result_t;

  // Clock, reset and unit ports
  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  logic [PERIOD_W-1:0]    cfg_data       = '0;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic [1:0]             command        = '0;
  logic [SAMPLE_BITS-1:0] adc_sample     = '0;
  logic                   new_cycle      = 1'b0;
  logic [RROW_W-1:0]      read_row       = '0;
  logic [RPOS_W-1:0]      read_position  = '0;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic                   capture_status;
  logic                   stored;
  logic                   overflow;
  logic [SAMPLE_BITS-1:0] read_sample;
  logic [RLEN_W-1:0]      read_length;

  // Stimulus and scoreboard
  capture_item_t   pending_items[$];
  capture_result_t results_due[$];
  capture_item_t   cur_item;
  logic            quiet = 1'b0;
  int              n_queued = 0;
  int              n_accepted = 0;
  int              n_checked = 0;
  int              n_errors = 0;
  int              n_cfg_writes = 0;
  int              n_stores = 0;
  int              n_drops = 0;
  int              n_completed = 0;
  int              n_read_hits = 0;

  // Capture model state
  logic [PERIOD_W-1:0]    period_reg;
  phase_t                 cap_phase;
  logic                   edge_seen;
  logic [ROW_IDX_W-1:0]   cur_row;
  logic [PERIOD_W-1:0]    period_count;
  logic                   cap_status;
  logic [LEN_W-1:0]       row_fill [NUM_ROWS];
  logic [SAMPLE_BITS-1:0] sample_mem [MEM_DEPTH];

  line_synced_cycle_capture_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .adc_sample     (adc_sample),
    .new_cycle      (new_cycle),
    .read_row       (read_row),
    .read_position  (read_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .capture_status (capture_status),
    .stored         (stored),
    .overflow       (overflow),
    .read_sample    (read_sample),
    .read_length    (read_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Capture model
  // --------------------------------------------------------------------------
  task automatic reset_model();
    period_reg   = PERIOD_RESET;
    cap_phase    = PH_START;
    edge_seen    = 1'b0;
    cur_row      = '0;
    period_count = '0;
    cap_status   = 1'b1;
    foreach (row_fill[i]) row_fill[i] = '0;
  endtask

  // Countdown expiry or edge: reload, maybe advance row, then end, drop or append
  function automatic void take_sample(input logic [SAMPLE_BITS-1:0] adc,
                                      output logic st, output logic ov);
    logic [LEN_W-1:0] len;
    st = 1'b0;
    ov = 1'b0;
    period_count = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    cap_phase = PH_WAITING;
    if (edge_seen) begin
      edge_seen = 1'b0;
      cur_row = cur_row + 1'b1;
    end
    if (cur_row >= NUM_ROWS) begin
      cap_phase = PH_EOC;
      cap_status = 1'b1;
      n_completed++;
      return;
    end
    len = row_fill[cur_row];
    if (len >= ROW_DEPTH) begin
      ov = 1'b1;
      n_drops++;
      return;
    end
    sample_mem[cur_row * ROW_DEPTH + len] = adc;
    row_fill[cur_row] = len + 1'b1;
    st = 1'b1;
    n_stores++;
  endfunction

  function automatic capture_result_t predict_capture(capture_item_t it);
    capture_result_t r;
    logic st, ov;
    r  = '0;
    st = 1'b0;
    ov = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (it.new_cycle) edge_seen = 1'b1;
        case (cap_phase)
          PH_START: begin
            if (edge_seen) begin
              edge_seen  = 1'b0;
              cap_phase  = PH_SAMPLING;
              cap_status = 1'b0;
            end
          end
          PH_SAMPLING: take_sample(it.adc, st, ov);
          PH_WAITING: begin
            if (period_count > 0) period_count = period_count - 1'b1;
            if (period_count == '0 || edge_seen) take_sample(it.adc, st, ov);
          end
          PH_EOC: ;
        endcase
      end
      CMD_CLEAR: begin
        cap_phase    = PH_START;
        edge_seen    = 1'b0;
        cur_row      = '0;
        period_count = '0;
        cap_status   = 1'b1;
        foreach (row_fill[i]) row_fill[i] = '0;
      end
      CMD_READ: begin
        if (it.row < NUM_ROWS) begin
          r.length = row_fill[it.row];
          if (it.pos < row_fill[it.row] && it.pos < ROW_DEPTH) begin
            r.sample = sample_mem[it.row * ROW_DEPTH + it.pos];
            n_read_hits++;
          end
        end
      end
      default: ;  // unused code: status only
    endcase
    r.status   = cap_status;
    r.stored   = st;
    r.overflow = ov;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one item from the pending queue per free slot, random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(predict_capture(cur_item));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
          cur_item      = pending_items.pop_front();
          in_valid      <= 1'b1;
          command       <= cur_item.command;
          adc_sample    <= cur_item.adc;
          new_cycle     <= cur_item.new_cycle;
          read_row      <= cur_item.row;
          read_position <= cur_item.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    capture_result_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.status   = capture_status;
        got.stored   = stored;
        got.overflow = overflow;
        got.sample   = read_sample;
        got.length   = read_length;
        if (results_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result with nothing expected: status %b stored %b ovf %b",
                     $realtime, got.status, got.stored, got.overflow,
                     " sample %h len %0d", got.sample, got.length);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: result %0d mismatch (exp/got): status %b/%b stored %b/%b",
                       $realtime, n_checked, want.status, got.status,
                       want.stored, got.stored,
                       " ovf %b/%b sample %h/%h len %0d/%0d",
                       want.overflow, got.overflow, want.sample, got.sample,
                       want.length, got.length);
          end
          n_checked++;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: cycles with no transfer on any channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $realtime, STALL_LIMIT, results_due.size());
    $display("line_synced_cycle_capture_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [SAMPLE_BITS-1:0] rand_adc();
    return SAMPLE_BITS'($urandom_range(4095));
  endfunction

  function automatic logic [RROW_W-1:0] rand_row();
    return RROW_W'($urandom_range(7));
  endfunction

  function automatic logic [RPOS_W-1:0] rand_pos();
    return RPOS_W'($urandom_range(127));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic queue_item(logic [1:0] cmd, logic [SAMPLE_BITS-1:0] adc, logic nc,
                            logic [RROW_W-1:0] row, logic [RPOS_W-1:0] pos);
    capture_item_t it;
    it.command   = cmd;
    it.adc       = adc;
    it.new_cycle = nc;
    it.row       = row;
    it.pos       = pos;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic queue_tick(logic nc);
    queue_item(CMD_TICK, rand_adc(), nc, rand_row(), rand_pos());
  endtask

  // Reads lean toward low positions, which are more often filled
  task automatic queue_read();
    logic [RPOS_W-1:0] pos;
    pos = RPOS_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(127));
    queue_item(CMD_READ, rand_adc(), rand_bit(), rand_row(), pos);
  endtask

  // Ordinary tick most of the time; now and then a read, a stray code,
  // an early edge or a clear that breaks the capture
  task automatic queue_row_tick();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)
      queue_read();
    else if (roll < 10)
      queue_item(CMD_UNUSED, rand_adc(), rand_bit(), rand_row(), rand_pos());
    else if (roll == 10)
      queue_item(CMD_CLEAR, rand_adc(), rand_bit(), rand_row(), rand_pos());
    else if (roll < 14)
      queue_tick(1'b1);
    else
      queue_tick(1'b0);
  endtask

  // One capture: clear, arm on an edge, one row per mains cycle until done
  task automatic queue_capture(bit long_rows);
    int ticks;
    queue_item(CMD_CLEAR, rand_adc(), rand_bit(), rand_row(), rand_pos());
    repeat ($urandom_range(3)) queue_tick(1'b0);
    queue_tick(1'b1);
    for (int r = 0; r < NUM_ROWS; r++) begin
      ticks = $urandom_range(1, 16);
      if (long_rows && $urandom_range(4) == 0) begin
        // overfill the row: plain ticks only
        ticks = ROW_DEPTH + $urandom_range(2, 12);
        repeat (ticks - 1) queue_tick(1'b0);
      end else begin
        repeat (ticks - 1) queue_row_tick();
      end
      queue_tick(1'b1);
    end
    repeat ($urandom_range(1, 3)) queue_tick(rand_bit());
    repeat ($urandom_range(2, 6)) queue_read();
  endtask

  // Sender holds off until every queued item has its result back
  task automatic wait_idle();
    do @(posedge clk); while (n_checked != n_queued);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    wait_idle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_reg = value;
    n_cfg_writes++;
  endtask

  task automatic run_phase(logic [PERIOD_W-1:0] period, bit long_rows, int budget);
    int start_count;
    write_period(period);
    start_count = n_queued;
    while (n_queued - start_count < budget) queue_capture(long_rows);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_count;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, arming, row advance on edges, clear, end of capture
    queue_item(CMD_READ,   12'hFFF, 1'b1, 3'd0, 7'd0);
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd7, 7'd127);
    queue_item(CMD_TICK,   12'hFFF, 1'b0, 3'd7, 7'd127);  // no edge yet
    queue_item(CMD_UNUSED, 12'hFFF, 1'b1, 3'd7, 7'd127);
    queue_item(CMD_TICK,   12'h000, 1'b1, 3'd0, 7'd0);    // first edge arms
    queue_item(CMD_TICK,   12'hFFF, 1'b0, 3'd0, 7'd0);    // row 0, pos 0
    queue_item(CMD_TICK,   12'h000, 1'b0, 3'd0, 7'd0);    // countdown running
    queue_item(CMD_TICK,   12'hABC, 1'b1, 3'd0, 7'd0);    // edge forces row 1
    queue_item(CMD_TICK,   12'h543, 1'b1, 3'd0, 7'd0);    // row 2
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd0, 7'd0);
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd1, 7'd0);
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd2, 7'd1);    // past row length
    queue_item(CMD_CLEAR,  12'hFFF, 1'b1, 3'd7, 7'd127);  // edge with clear is lost
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd0, 7'd0);    // old data unreachable
    queue_item(CMD_TICK,   12'h001, 1'b0, 3'd0, 7'd0);    // still waiting for edge
    queue_item(CMD_TICK,   12'h800, 1'b1, 3'd0, 7'd0);
    repeat (NUM_ROWS) queue_item(CMD_TICK, 12'h7FF, 1'b1, 3'd0, 7'd0);  // last one ends it
    queue_item(CMD_TICK,   12'hFFF, 1'b1, 3'd0, 7'd0);    // done: ignored
    queue_item(CMD_READ,   12'h000, 1'b0, 3'd7, 7'd0);

    // Random captures over several periods, extremes included
    run_phase(16'd1, 1'b1, 180);
    run_phase(16'd0, 1'b1, 180);
    run_phase(16'hFFFF, 1'b0, 150);
    quiet = 1'b1;
    run_phase(16'd2, 1'b0, 180);
    wait_idle();
    quiet = 1'b0;
    run_phase(PERIOD_W'($urandom_range(3, 40)), 1'b0, 180);
    write_period(PERIOD_RESET);
    queue_capture(1'b0);
    wait_idle();
    start_count = n_queued;
    while (n_queued - start_count < 150) queue_capture(1'b0);

    // Drain, then give a stray result time to show up
    wait_idle();
    repeat (8) @(posedge clk);

    $display("%0d items over %0d period settings: %0d samples stored, %0d dropped on full rows,",
             n_accepted, n_cfg_writes, n_stores, n_drops);
    $display("%0d captures completed, %0d reads returned stored data, %0d results checked",
             n_completed, n_read_hits, n_checked);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("line_synced_cycle_capture_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, results_due.size());
      $display("line_synced_cycle_capture_unit verification failed");
    end
    $finish;
  end

endmodule
